// ----- hw/rtl/apms_pkg.sv -----
// ----------------------------------------------------------------------------
// apms_pkg
// Shared types and constants for the arm pickup motion sequencer: phase
// codes, register indexes, speed commands and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package apms_pkg;

    localparam int POT_BITS  = 10;
    localparam int POT_W     = 10;
    localparam int CFG_W     = 10;
    localparam int TICK_W    = 11;
    localparam int SPD_W     = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [POT_W-1:0]  POT_MASK = POT_W'((64'd1 << POT_BITS) - 64'd1);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [2:0] {
        PH_RAISE_ELBOW = 3'd0,
        PH_RAISE_ARM   = 3'd1,
        PH_RELEASE     = 3'd2,
        PH_LOWER_ARM   = 3'd3,
        PH_LOWER_ELBOW = 3'd4,
        PH_DONE        = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAISE_ELBOW_TIMEOUT   = 3'd0,
        CFG_RAISE_ARM_TIMEOUT     = 3'd1,
        CFG_POT_TOP_THRESHOLD     = 3'd2,
        CFG_POT_RELEASE_THRESHOLD = 3'd3,
        CFG_RELEASE_TIMEOUT       = 3'd4,
        CFG_POT_BOTTOM_THRESHOLD  = 3'd5,
        CFG_LOWER_ELBOW_TIMEOUT   = 3'd6
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] RST_RAISE_ELBOW_TIMEOUT   = 10'd20;
    localparam logic [CFG_W-1:0] RST_RAISE_ARM_TIMEOUT     = 10'd300;
    localparam logic [CFG_W-1:0] RST_POT_TOP_THRESHOLD     = 10'd500;
    localparam logic [CFG_W-1:0] RST_POT_RELEASE_THRESHOLD = 10'd450;
    localparam logic [CFG_W-1:0] RST_RELEASE_TIMEOUT       = 10'd30;
    localparam logic [CFG_W-1:0] RST_POT_BOTTOM_THRESHOLD  = 10'd5;
    localparam logic [CFG_W-1:0] RST_LOWER_ELBOW_TIMEOUT   = 10'd20;

    localparam logic signed [SPD_W-1:0] SPD_FULL_UP   = 8'sd127;
    localparam logic signed [SPD_W-1:0] SPD_SLOW_UP   = 8'sd60;
    localparam logic signed [SPD_W-1:0] SPD_FULL_DOWN = -8'sd127;
    localparam logic signed [SPD_W-1:0] SPD_HOLD      = 8'sd50;
    localparam logic signed [SPD_W-1:0] SPD_OFF       = 8'sd0;

endpackage

`default_nettype wire

// ----- hw/rtl/arm_pickup_motion_sequencer.sv -----
// ----------------------------------------------------------------------------
// arm_pickup_motion_sequencer
// Five-phase elbow/shoulder motion sequencer with an APB register port.
// ----------------------------------------------------------------------------
// Every item (start request or control tick) yields exactly one result. The
// block takes one item per clock cycle while item_stall is low: the phase, tick
// counter and done flag update at the edge that accepts an item, and the result
// goes into a single output register at that same edge. item_stall is high only
// while that output register holds a result that the far side is stalling, so
// throughput is one item per cycle whenever result_stall is low.
// Registers 0..6 lie at byte addresses 0x00..0x18; write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_pickup_motion_sequencer (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [apms_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [apms_pkg::DATA_W-1:0]           pwdata,
    output logic      [apms_pkg::DATA_W-1:0]           prdata,
    output logic                                       pready,

    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic                                  req_type,
    input  wire logic [apms_pkg::POT_W-1:0]            shoulder_pot,

    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic                                       elbow_drive,
    output logic signed [apms_pkg::SPD_W-1:0]          elbow_speed,
    output logic                                       shoulder_drive,
    output logic signed [apms_pkg::SPD_W-1:0]          shoulder_speed,
    output logic                                       seq_done,
    output logic      [2:0]                            phase_now
);

    logic [apms_pkg::CFG_W-1:0] raise_elbow_timeout_reg;
    logic [apms_pkg::CFG_W-1:0] raise_arm_timeout_reg;
    logic [apms_pkg::CFG_W-1:0] pot_top_threshold_reg;
    logic [apms_pkg::CFG_W-1:0] pot_release_threshold_reg;
    logic [apms_pkg::CFG_W-1:0] release_timeout_reg;
    logic [apms_pkg::CFG_W-1:0] pot_bottom_threshold_reg;
    logic [apms_pkg::CFG_W-1:0] lower_elbow_timeout_reg;

    logic                                cfg_write;
    logic [apms_pkg::CFG_IDX_W-1:0]      cfg_idx;
    logic [apms_pkg::CFG_W-1:0]          cfg_data;
    logic [apms_pkg::CFG_W-1:0]          rd_data;

    apms_pkg::phase_t                    phase_reg, phase_next;
    logic [apms_pkg::TICK_W-1:0]         ticks_reg, ticks_next, ticks_inc;
    logic                                done_reg, done_next;

    logic [apms_pkg::POT_W-1:0]          pot;
    logic                                accept;
    logic                                e_drv, s_drv;
    logic signed [apms_pkg::SPD_W-1:0]   e_spd, s_spd;

    logic                                result_valid_reg;
    logic                                elbow_drive_reg, shoulder_drive_reg, seq_done_reg;
    logic signed [apms_pkg::SPD_W-1:0]   elbow_speed_reg, shoulder_speed_reg;
    logic [2:0]                          phase_now_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[apms_pkg::ADDR_W-1:2];
    assign cfg_data  = pwdata[apms_pkg::CFG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raise_elbow_timeout_reg   <= apms_pkg::RST_RAISE_ELBOW_TIMEOUT;
            raise_arm_timeout_reg     <= apms_pkg::RST_RAISE_ARM_TIMEOUT;
            pot_top_threshold_reg     <= apms_pkg::RST_POT_TOP_THRESHOLD;
            pot_release_threshold_reg <= apms_pkg::RST_POT_RELEASE_THRESHOLD;
            release_timeout_reg       <= apms_pkg::RST_RELEASE_TIMEOUT;
            pot_bottom_threshold_reg  <= apms_pkg::RST_POT_BOTTOM_THRESHOLD;
            lower_elbow_timeout_reg   <= apms_pkg::RST_LOWER_ELBOW_TIMEOUT;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                apms_pkg::CFG_RAISE_ELBOW_TIMEOUT:   raise_elbow_timeout_reg   <= cfg_data;
                apms_pkg::CFG_RAISE_ARM_TIMEOUT:     raise_arm_timeout_reg     <= cfg_data;
                apms_pkg::CFG_POT_TOP_THRESHOLD:     pot_top_threshold_reg     <= cfg_data;
                apms_pkg::CFG_POT_RELEASE_THRESHOLD: pot_release_threshold_reg <= cfg_data;
                apms_pkg::CFG_RELEASE_TIMEOUT:       release_timeout_reg       <= cfg_data;
                apms_pkg::CFG_POT_BOTTOM_THRESHOLD:  pot_bottom_threshold_reg  <= cfg_data;
                apms_pkg::CFG_LOWER_ELBOW_TIMEOUT:   lower_elbow_timeout_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            apms_pkg::CFG_RAISE_ELBOW_TIMEOUT:   rd_data = raise_elbow_timeout_reg;
            apms_pkg::CFG_RAISE_ARM_TIMEOUT:     rd_data = raise_arm_timeout_reg;
            apms_pkg::CFG_POT_TOP_THRESHOLD:     rd_data = pot_top_threshold_reg;
            apms_pkg::CFG_POT_RELEASE_THRESHOLD: rd_data = pot_release_threshold_reg;
            apms_pkg::CFG_RELEASE_TIMEOUT:       rd_data = release_timeout_reg;
            apms_pkg::CFG_POT_BOTTOM_THRESHOLD:  rd_data = pot_bottom_threshold_reg;
            apms_pkg::CFG_LOWER_ELBOW_TIMEOUT:   rd_data = lower_elbow_timeout_reg;
            default:                             rd_data = '0;
        endcase
    end

    assign prdata = {{(apms_pkg::DATA_W-apms_pkg::CFG_W){1'b0}}, rd_data};

    // Item handshake
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign pot       = shoulder_pot & apms_pkg::POT_MASK;
    assign ticks_inc = (ticks_reg == apms_pkg::TICK_MAX) ? ticks_reg
                                                         : ticks_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        ticks_next = ticks_reg;
        done_next  = done_reg;
        e_drv      = 1'b0;
        s_drv      = 1'b0;
        e_spd      = apms_pkg::SPD_OFF;
        s_spd      = apms_pkg::SPD_OFF;

        if (!req_type)
        begin
            phase_next = apms_pkg::PH_RAISE_ELBOW;
            ticks_next = '0;
            done_next  = 1'b0;
        end
        else
        begin
            case (phase_reg)
                apms_pkg::PH_RAISE_ELBOW:
                begin
                    if (ticks_reg > {1'b0, raise_elbow_timeout_reg})
                    begin
                        phase_next = apms_pkg::PH_RAISE_ARM;
                        ticks_next = '0;
                    end
                    else
                    begin
                        e_drv      = 1'b1;
                        e_spd      = apms_pkg::SPD_FULL_UP;
                        ticks_next = ticks_inc;
                    end
                end
                apms_pkg::PH_RAISE_ARM:
                begin
                    if (ticks_reg > {1'b0, raise_arm_timeout_reg})
                    begin
                        phase_next = apms_pkg::PH_DONE;
                        ticks_next = '0;
                        done_next  = 1'b1;
                    end
                    else if (pot > pot_top_threshold_reg)
                    begin
                        phase_next = apms_pkg::PH_RELEASE;
                        ticks_next = '0;
                    end
                    else
                    begin
                        s_drv      = 1'b1;
                        s_spd      = apms_pkg::SPD_FULL_UP;
                        e_drv      = 1'b1;
                        e_spd      = (pot > pot_release_threshold_reg) ? apms_pkg::SPD_FULL_DOWN
                                                                       : apms_pkg::SPD_SLOW_UP;
                        ticks_next = ticks_inc;
                    end
                end
                apms_pkg::PH_RELEASE:
                begin
                    if (ticks_reg > {1'b0, release_timeout_reg})
                    begin
                        phase_next = apms_pkg::PH_LOWER_ARM;
                        ticks_next = '0;
                    end
                    else
                    begin
                        e_drv      = 1'b1;
                        e_spd      = apms_pkg::SPD_FULL_DOWN;
                        s_drv      = 1'b1;
                        s_spd      = apms_pkg::SPD_HOLD;
                        ticks_next = ticks_inc;
                    end
                end
                apms_pkg::PH_LOWER_ARM:
                begin
                    if (pot < pot_bottom_threshold_reg)
                    begin
                        phase_next = apms_pkg::PH_LOWER_ELBOW;
                        ticks_next = '0;
                    end
                    else
                    begin
                        s_drv = 1'b1;
                        s_spd = apms_pkg::SPD_FULL_DOWN;
                    end
                end
                apms_pkg::PH_LOWER_ELBOW:
                begin
                    if (ticks_reg > {1'b0, lower_elbow_timeout_reg})
                    begin
                        phase_next = apms_pkg::PH_DONE;
                        ticks_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        e_drv      = 1'b1;
                        e_spd      = apms_pkg::SPD_FULL_DOWN;
                        ticks_next = ticks_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= apms_pkg::PH_RAISE_ELBOW;
            ticks_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            ticks_reg <= ticks_next;
            done_reg  <= done_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elbow_drive_reg    <= e_drv;
            elbow_speed_reg    <= e_spd;
            shoulder_drive_reg <= s_drv;
            shoulder_speed_reg <= s_spd;
            seq_done_reg       <= done_next;
            phase_now_reg      <= phase_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign elbow_drive    = elbow_drive_reg;
    assign elbow_speed    = elbow_speed_reg;
    assign shoulder_drive = shoulder_drive_reg;
    assign shoulder_speed = shoulder_speed_reg;
    assign seq_done       = seq_done_reg;
    assign phase_now      = phase_now_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/apms_checker.sv -----
// ----------------------------------------------------------------------------
// apms_checker
// Port-level checks for the arm pickup motion sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module apms_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              result_valid,
    input  wire logic                              result_stall,
    input  wire logic                              elbow_drive,
    input  wire logic signed [apms_pkg::SPD_W-1:0] elbow_speed,
    input  wire logic                              shoulder_drive,
    input  wire logic signed [apms_pkg::SPD_W-1:0] shoulder_speed,
    input  wire logic                              seq_done,
    input  wire logic [2:0]                        phase_now
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled item dropped");

    a_idle_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (elbow_drive || elbow_speed == '0) &&
                         (shoulder_drive || shoulder_speed == '0))
        else $error("speed without drive");

    a_done_phase_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && phase_now == apms_pkg::PH_DONE |-> seq_done)
        else $error("done phase without done flag");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && seq_done |->
            !elbow_drive && !shoulder_drive && phase_now == apms_pkg::PH_DONE)
        else $error("motor driven after done");

endmodule

bind arm_pickup_motion_sequencer apms_checker u_apms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .elbow_drive    (elbow_drive),
    .elbow_speed    (elbow_speed),
    .shoulder_drive (shoulder_drive),
    .shoulder_speed (shoulder_speed),
    .seq_done       (seq_done),
    .phase_now      (phase_now)
);

`default_nettype wire

// ----- tb/sv/tb_arm_pickup_motion_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_arm_pickup_motion_sequencer
// Self-checking bench for the five-phase arm pickup motion sequencer.
// ----------------------------------------------------------------------------
// Registers are written over the APB port while the block is idle. Start
// requests and control ticks go in through the item channel, and a built-in
// phase/tick predictor works out the motor commands, done flag and phase
// for each accepted item. Results are checked field by field in order.
// Directed walks cover every phase, the arm-raise abort and the done phase.
// Random traffic then runs under default, all-zero, small random and
// all-max register settings, with pot readings steered around the active
// thresholds, and with random sender gaps and receiver stalls in the first two.
// ----------------------------------------------------------------------------
module tb_arm_pickup_motion_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NUM_CFG_REGS = 7;
    localparam int  REG_BYTES    = 4;
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  POT_MAX      = 1023;
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct {
        logic                              e_drv;
        logic signed [apms_pkg::SPD_W-1:0] e_spd;
        logic                              s_drv;
        logic signed [apms_pkg::SPD_W-1:0] s_spd;
        logic                              done;
        logic [2:0]                        ph;
    } motion_cmd_t;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [apms_pkg::ADDR_W-1:0]       paddr;
    logic [apms_pkg::DATA_W-1:0]       pwdata;
    logic [apms_pkg::DATA_W-1:0]       prdata;
    logic                              pready;
    logic                              item_valid;
    logic                              item_stall;
    logic                              req_type;
    logic [apms_pkg::POT_W-1:0]        shoulder_pot;
    logic                              result_valid;
    logic                              result_stall;
    logic                              elbow_drive;
    logic signed [apms_pkg::SPD_W-1:0] elbow_speed;
    logic                              shoulder_drive;
    logic signed [apms_pkg::SPD_W-1:0] shoulder_speed;
    logic                              seq_done;
    logic [2:0]                        phase_now;

    logic [apms_pkg::CFG_W-1:0]  cfg_model [NUM_CFG_REGS];
    apms_pkg::phase_t            seq_phase;
    logic [apms_pkg::TICK_W-1:0] seq_ticks;
    logic                        seq_done_flag;

    motion_cmd_t pending_cmds[$];
    motion_cmd_t head_cmd;
    int          mismatches;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    arm_pickup_motion_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .req_type       (req_type),
        .shoulder_pot   (shoulder_pot),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .elbow_drive    (elbow_drive),
        .elbow_speed    (elbow_speed),
        .shoulder_drive (shoulder_drive),
        .shoulder_speed (shoulder_speed),
        .seq_done       (seq_done),
        .phase_now      (phase_now)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("arm_pickup_motion_sequencer test failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $realtime, label, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual phase %0d",
                         $realtime, phase_now);
            end
            else
            begin
                head_cmd = pending_cmds.pop_front();
                check_field("elbow_drive", head_cmd.e_drv, elbow_drive);
                check_field("elbow_speed", head_cmd.e_spd, elbow_speed);
                check_field("shoulder_drive", head_cmd.s_drv, shoulder_drive);
                check_field("shoulder_speed", head_cmd.s_spd, shoulder_speed);
                check_field("seq_done", head_cmd.done, seq_done);
                check_field("phase_now", head_cmd.ph, phase_now);
            end
        end
    end

    function automatic void enter_phase(input apms_pkg::phase_t next_ph);
        seq_phase = next_ph;
        seq_ticks = '0;
        if (next_ph == apms_pkg::PH_DONE)
            seq_done_flag = 1'b1;
    endfunction

    function automatic void count_tick();
        if (seq_ticks != apms_pkg::TICK_MAX)
            seq_ticks++;
    endfunction

    function automatic void predict_motion(input logic rt,
                                           input logic [apms_pkg::POT_W-1:0] raw_pot);
        motion_cmd_t                cmd;
        logic [apms_pkg::POT_W-1:0] pot;
        pot       = raw_pot & apms_pkg::POT_MASK;
        cmd.e_drv = 1'b0;
        cmd.e_spd = apms_pkg::SPD_OFF;
        cmd.s_drv = 1'b0;
        cmd.s_spd = apms_pkg::SPD_OFF;
        if (rt == REQ_START)
        begin
            seq_phase     = apms_pkg::PH_RAISE_ELBOW;
            seq_ticks     = '0;
            seq_done_flag = 1'b0;
        end
        else
        begin
            case (seq_phase)
                apms_pkg::PH_RAISE_ELBOW:
                begin
                    if (seq_ticks > cfg_model[apms_pkg::CFG_RAISE_ELBOW_TIMEOUT])
                        enter_phase(apms_pkg::PH_RAISE_ARM);
                    else
                    begin
                        cmd.e_drv = 1'b1;
                        cmd.e_spd = apms_pkg::SPD_FULL_UP;
                        count_tick();
                    end
                end
                apms_pkg::PH_RAISE_ARM:
                begin
                    if (seq_ticks > cfg_model[apms_pkg::CFG_RAISE_ARM_TIMEOUT])
                        enter_phase(apms_pkg::PH_DONE);
                    else if (pot > cfg_model[apms_pkg::CFG_POT_TOP_THRESHOLD])
                        enter_phase(apms_pkg::PH_RELEASE);
                    else
                    begin
                        cmd.s_drv = 1'b1;
                        cmd.s_spd = apms_pkg::SPD_FULL_UP;
                        cmd.e_drv = 1'b1;
                        cmd.e_spd = (pot > cfg_model[apms_pkg::CFG_POT_RELEASE_THRESHOLD]) ?
                                    apms_pkg::SPD_FULL_DOWN : apms_pkg::SPD_SLOW_UP;
                        count_tick();
                    end
                end
                apms_pkg::PH_RELEASE:
                begin
                    if (seq_ticks > cfg_model[apms_pkg::CFG_RELEASE_TIMEOUT])
                        enter_phase(apms_pkg::PH_LOWER_ARM);
                    else
                    begin
                        cmd.e_drv = 1'b1;
                        cmd.e_spd = apms_pkg::SPD_FULL_DOWN;
                        cmd.s_drv = 1'b1;
                        cmd.s_spd = apms_pkg::SPD_HOLD;
                        count_tick();
                    end
                end
                apms_pkg::PH_LOWER_ARM:
                begin
                    if (pot < cfg_model[apms_pkg::CFG_POT_BOTTOM_THRESHOLD])
                        enter_phase(apms_pkg::PH_LOWER_ELBOW);
                    else
                    begin
                        cmd.s_drv = 1'b1;
                        cmd.s_spd = apms_pkg::SPD_FULL_DOWN;
                    end
                end
                apms_pkg::PH_LOWER_ELBOW:
                begin
                    if (seq_ticks > cfg_model[apms_pkg::CFG_LOWER_ELBOW_TIMEOUT])
                        enter_phase(apms_pkg::PH_DONE);
                    else
                    begin
                        cmd.e_drv = 1'b1;
                        cmd.e_spd = apms_pkg::SPD_FULL_DOWN;
                        count_tick();
                    end
                end
                default:
                begin
                end
            endcase
        end
        cmd.done = seq_done_flag;
        cmd.ph   = seq_phase;
        pending_cmds.push_back(cmd);
    endfunction

    // Entered and left at a falling edge; valid stays high for back-to-back items.
    task automatic send_item(input logic rt, input logic [apms_pkg::POT_W-1:0] pot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        req_type     <= rt;
        shoulder_pot <= pot;
        do
            @(posedge clk);
        while (item_stall);
        predict_motion(rt, pot);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input int idx, input logic [apms_pkg::DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= apms_pkg::ADDR_W'(idx * REG_BYTES);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx < NUM_CFG_REGS)
            cfg_model[idx] = data[apms_pkg::CFG_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_all_config(input int re_to, input int ra_to, input int top_th,
                                  input int rel_th, input int rls_to, input int bot_th,
                                  input int le_to);
        cfg_write(apms_pkg::CFG_RAISE_ELBOW_TIMEOUT,
                  {10'($urandom_range(1023)), 22'd0} | 32'(re_to));
        cfg_write(apms_pkg::CFG_RAISE_ARM_TIMEOUT,     ra_to);
        cfg_write(apms_pkg::CFG_POT_TOP_THRESHOLD,
                  {10'($urandom_range(1023)), 22'd0} | 32'(top_th));
        cfg_write(apms_pkg::CFG_POT_RELEASE_THRESHOLD, rel_th);
        cfg_write(apms_pkg::CFG_RELEASE_TIMEOUT,       rls_to);
        cfg_write(apms_pkg::CFG_POT_BOTTOM_THRESHOLD,  bot_th);
        cfg_write(apms_pkg::CFG_LOWER_ELBOW_TIMEOUT,   le_to);
    endtask

    function automatic logic [apms_pkg::POT_W-1:0] pick_pot();
        int th;
        int v;
        case (seq_phase)
            apms_pkg::PH_RAISE_ARM:
                th = $urandom_range(1) ? cfg_model[apms_pkg::CFG_POT_TOP_THRESHOLD] :
                                         cfg_model[apms_pkg::CFG_POT_RELEASE_THRESHOLD];
            apms_pkg::PH_LOWER_ARM:
                th = cfg_model[apms_pkg::CFG_POT_BOTTOM_THRESHOLD];
            default:
                th = $urandom_range(POT_MAX);
        endcase
        case ($urandom_range(3))
            0:       v = $urandom_range(POT_MAX);
            1:       v = $urandom_range(1) ? POT_MAX : 0;
            default: v = th + int'($urandom_range(4)) - 2;
        endcase
        if (v < 0)
            v = 0;
        if (v > POT_MAX)
            v = POT_MAX;
        return v[apms_pkg::POT_W-1:0];
    endfunction

    task automatic run_random(input int n_items, input int start_pct);
        logic rt;
        repeat (n_items)
        begin
            rt = REQ_TICK;
            if ($urandom_range(99) < start_pct)
                rt = REQ_START;
            else if (seq_phase == apms_pkg::PH_DONE && $urandom_range(3) == 0)
                rt = REQ_START;
            send_item(rt, pick_pot());
        end
        wait_idle();
    endtask

    task automatic test_full_sequence();
        set_all_config(1, 3, 600, 400, 0, 5, 1);
        send_item(REQ_START, 10'd1023);
        send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd1023);
        send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd300);
        send_item(REQ_TICK, 10'd500);
        send_item(REQ_TICK, 10'd1023);
        send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd1023);
        send_item(REQ_TICK, 10'd5);
        send_item(REQ_TICK, 10'd4);
        send_item(REQ_TICK, 10'd1023);
        send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd0);
        wait_idle();
    endtask

    task automatic test_arm_raise_abort();
        send_item(REQ_START, 10'd0);
        repeat (3) send_item(REQ_TICK, 10'd600);
        repeat (5) send_item(REQ_TICK, 10'd0);
        send_item(REQ_TICK, 10'd1023);
        wait_idle();
    endtask

    task automatic test_random_defaults();
        set_all_config(apms_pkg::RST_RAISE_ELBOW_TIMEOUT, apms_pkg::RST_RAISE_ARM_TIMEOUT,
                       apms_pkg::RST_POT_TOP_THRESHOLD, apms_pkg::RST_POT_RELEASE_THRESHOLD,
                       apms_pkg::RST_RELEASE_TIMEOUT, apms_pkg::RST_POT_BOTTOM_THRESHOLD,
                       apms_pkg::RST_LOWER_ELBOW_TIMEOUT);
        cfg_write(NUM_CFG_REGS, $urandom());
        run_random(130, 2);
    endtask

    task automatic test_random_zero_config();
        set_all_config(0, 0, 0, 0, 0, 0, 0);
        run_random(130, 4);
    endtask

    task automatic test_random_small_config();
        set_all_config($urandom_range(15), $urandom_range(15), $urandom_range(POT_MAX),
                       $urandom_range(POT_MAX), $urandom_range(15),
                       $urandom_range(POT_MAX), $urandom_range(15));
        run_random(100, 3);
    endtask

    task automatic test_random_max_config();
        set_all_config(POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MAX, POT_MAX);
        run_random(40, 3);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        item_valid     = 1'b0;
        req_type       = REQ_START;
        shoulder_pot   = '0;
        result_stall   = 1'b0;
        mismatches     = 0;
        cycle_count    = 0;
        cfg_model[apms_pkg::CFG_RAISE_ELBOW_TIMEOUT]   = apms_pkg::RST_RAISE_ELBOW_TIMEOUT;
        cfg_model[apms_pkg::CFG_RAISE_ARM_TIMEOUT]     = apms_pkg::RST_RAISE_ARM_TIMEOUT;
        cfg_model[apms_pkg::CFG_POT_TOP_THRESHOLD]     = apms_pkg::RST_POT_TOP_THRESHOLD;
        cfg_model[apms_pkg::CFG_POT_RELEASE_THRESHOLD] = apms_pkg::RST_POT_RELEASE_THRESHOLD;
        cfg_model[apms_pkg::CFG_RELEASE_TIMEOUT]       = apms_pkg::RST_RELEASE_TIMEOUT;
        cfg_model[apms_pkg::CFG_POT_BOTTOM_THRESHOLD]  = apms_pkg::RST_POT_BOTTOM_THRESHOLD;
        cfg_model[apms_pkg::CFG_LOWER_ELBOW_TIMEOUT]   = apms_pkg::RST_LOWER_ELBOW_TIMEOUT;
        seq_phase      = apms_pkg::PH_RAISE_ELBOW;
        seq_ticks      = '0;
        seq_done_flag  = 1'b0;

        send_idle_pct  = 38;
        recv_stall_pct = 88;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_full_sequence();
        test_arm_raise_abort();
        test_random_defaults();

        send_idle_pct  = 88;
        recv_stall_pct = 38;
        test_random_zero_config();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_small_config();
        test_random_max_config();

        if (mismatches == 0)
            $display("arm_pickup_motion_sequencer test passed");
        else
            $display("arm_pickup_motion_sequencer test failed");
        $finish;
    end

endmodule
